@@ src/tpr_pkg.sv @@
// Shared types, command codes and constants of the tyre pass recorder.
`default_nettype none

package tpr_pkg;

    // Field widths of one record, of a request and of the result.
    localparam int unsigned PULSE_W    = 27;
    localparam int unsigned INTERVAL_W = 29;
    localparam int unsigned QLEN_W     = 5;
    localparam int unsigned CMD_W      = 3;

    // Default ring depth handed to the top level.
    localparam int unsigned RING_DEPTH_DEF = 16;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 29;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_LIMIT = 2'd1;

    // Reset values of the limit registers.
    localparam logic [PULSE_W-1:0]    PULSE_LIMIT_RST    = 27'd100000000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_LIMIT_RST = 29'd360000000;

    // Command codes of a request.
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK_OLD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_NEW  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

    // One stored record.
    typedef struct packed {
        logic [PULSE_W-1:0]    pulse;
        logic [INTERVAL_W-1:0] interval;
        logic                  dbl;
    } rec_t;

    // Input request.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             press_level;
        logic             double_level;
    } in_t;

    // Result.
    typedef struct packed {
        logic                  empty_res;
        logic [PULSE_W-1:0]    pulse_count;
        logic [INTERVAL_W-1:0] interval_count;
        logic                  double_tyre;
        logic [QLEN_W-1:0]     queue_length;
        logic                  press_now;
        logic                  double_now;
    } out_t;

endpackage

`default_nettype wire

@@ src/tpr_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module tpr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/tpr_core.sv @@
// Sequencer of the tyre pass recorder: ring pointers, press tracking and result register.
`default_nettype none

module tpr_core #(
    parameter int unsigned RING_DEPTH = tpr_pkg::RING_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire tpr_pkg::in_t                        s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output tpr_pkg::out_t                            m_data,
    input  wire logic [tpr_pkg::PULSE_W-1:0]         pulse_limit,
    input  wire logic [tpr_pkg::INTERVAL_W-1:0]      interval_limit,
    output logic                                     ram_we,
    output logic [$clog2(RING_DEPTH)-1:0]            ram_waddr,
    output tpr_pkg::rec_t                            ram_wdata,
    output logic                                     ram_re,
    output logic [$clog2(RING_DEPTH)-1:0]            ram_raddr,
    input  wire tpr_pkg::rec_t                       ram_rdata
);

    import tpr_pkg::*;

    localparam int unsigned PW = $clog2(RING_DEPTH);
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     oldest_reg, oldest_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pressed_reg, pressed_next;
    logic [PULSE_W-1:0] run_reg, run_next;
    logic              press_smp_reg, press_smp_next;
    logic              dbl_smp_reg, dbl_smp_next;
    in_t               item_reg, item_next;
    out_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              commit;
    logic [PW-1:0]     newest_idx;
    logic [PW-1:0]     push_idx;
    logic [PW-1:0]     second_idx;
    logic [PULSE_W-1:0] run_base;
    logic              ring_empty;
    logic              ring_full;

    // Ring slot at a given offset from a base; the sum stays below twice the depth for offsets up to the depth.
    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(RING_DEPTH)) begin
            sum = sum - (CW+1)'(RING_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    assign newest_idx = slot_of(oldest_reg, count_reg - CW'(1));
    assign push_idx   = slot_of(oldest_reg, count_reg);
    assign second_idx = slot_of(oldest_reg, CW'(1));
    assign ring_empty = (count_reg == '0);
    assign ring_full  = (count_reg == CW'(RING_DEPTH));

    // A result leaves the execute step once the output register is free.
    assign commit  = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Read the entry a request needs as it is accepted.
    assign ram_re    = s_valid && s_ready;
    assign ram_raddr = ((s_data.command == CMD_POP) || (s_data.command == CMD_PEEK_OLD))
                       ? oldest_reg : newest_idx;

    // Next-state logic: execute one request from the read data.
    always_comb begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        pressed_next   = pressed_reg;
        run_next       = run_reg;
        press_smp_next = press_smp_reg;
        dbl_smp_next   = dbl_smp_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        ram_we         = 1'b0;
        ram_waddr      = newest_idx;
        ram_wdata      = ram_rdata;
        run_base       = pressed_reg ? run_reg : '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    out_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    unique case (item_reg.command)
                        CMD_TICK: begin
                            press_smp_next = item_reg.press_level;
                            dbl_smp_next   = item_reg.double_level;
                            // Gap count of the newest record rises while not pressed, up to the interval limit.
                            if (!pressed_reg && !ring_empty) begin
                                ram_we    = 1'b1;
                                ram_waddr = newest_idx;
                                ram_wdata = ram_rdata;
                                if (ram_rdata.interval < interval_limit) begin
                                    ram_wdata.interval = ram_rdata.interval +
                                                         INTERVAL_W'(1);
                                end
                            end
                            if (item_reg.press_level) begin
                                pressed_next = 1'b1;
                                run_next     = run_base;
                                if (run_base < pulse_limit) begin
                                    run_next = run_base + PULSE_W'(1);
                                end
                            end else if (pressed_reg) begin
                                // Release: push a record, overwriting the oldest if full.
                                pressed_next       = 1'b0;
                                ram_we             = 1'b1;
                                ram_waddr          = push_idx;
                                ram_wdata.pulse    = run_reg;
                                ram_wdata.interval = '0;
                                ram_wdata.dbl      = item_reg.double_level;
                                if (ring_full) begin
                                    oldest_next = second_idx;
                                end else begin
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        CMD_POP, CMD_PEEK_OLD, CMD_PEEK_NEW: begin
                            if (ring_empty) begin
                                out_next.empty_res = 1'b1;
                            end else begin
                                out_next.pulse_count    = ram_rdata.pulse;
                                out_next.interval_count = ram_rdata.interval;
                                out_next.double_tyre    = ram_rdata.dbl;
                                if (item_reg.command == CMD_POP) begin
                                    oldest_next = second_idx;
                                    count_next  = count_reg - CW'(1);
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            oldest_next = '0;
                            count_next  = '0;
                        end
                        default: begin
                            // Unused command codes leave the state alone.
                        end
                    endcase
                    out_next.queue_length = QLEN_W'(count_next);
                    out_next.press_now    = press_smp_next;
                    out_next.double_now   = dbl_smp_next;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            pressed_reg   <= 1'b0;
            run_reg       <= '0;
            press_smp_reg <= 1'b0;
            dbl_smp_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            pressed_reg   <= pressed_next;
            run_reg       <= run_next;
            press_smp_reg <= press_smp_next;
            dbl_smp_reg   <= dbl_smp_next;
            out_valid_reg <= out_valid_next;
        end
        item_reg <= item_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

@@ src/tyre_pass_recorder_top.sv @@
// Top level of the tyre pass recorder: limit registers, record ring memory and sequencer.
//
// The s_ channel takes one request per handshake: a tick that samples the sensor's
// press and single/double levels, a pop or peek of the oldest record, a peek of the
// newest record, or a clear of the ring. Every request gives exactly one result on
// the m_ channel with the record read (if any), the ring length after the request
// and the last sampled sensor levels.
// In the accept cycle a request reads the needed ring entry from the record memory; the
// execute step then modifies it, writes it back and loads the result register, which
// drives m_data. One request is in flight at a time, set by the single read-modify-write
// pass through the memory port; a new request is taken once the execute step is done.
// A new request is accepted while an earlier result still waits; if the receiver
// stalls, the next request waits in the execute step until the result register frees.
// The limit registers must be written through cfg_we, cfg_index and cfg_data only while
// the block is idle; the block itself does not enforce this. Synchronous reset empties
// the ring, clears the press tracking and restores the default limits; no clearing pass
// of the memory is needed.

`default_nettype none

module tyre_pass_recorder_top #(
    parameter int unsigned RING_DEPTH = tpr_pkg::RING_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire tpr_pkg::in_t                      s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output tpr_pkg::out_t                          m_data,
    input  wire logic                              cfg_we,
    input  wire logic [tpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tpr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import tpr_pkg::*;

    localparam int unsigned PW = $clog2(RING_DEPTH);

    logic [PULSE_W-1:0]    pulse_limit_reg;
    logic [INTERVAL_W-1:0] interval_limit_reg;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    rec_t          ram_wdata;
    logic          ram_re;
    logic [PW-1:0] ram_raddr;
    rec_t          ram_rdata;

    // Limit registers; writes to other indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_limit_reg    <= PULSE_LIMIT_RST;
            interval_limit_reg <= INTERVAL_LIMIT_RST;
        end else if (cfg_we) begin
            if (cfg_index == CFG_PULSE_LIMIT) begin
                pulse_limit_reg <= cfg_data[PULSE_W-1:0];
            end
            if (cfg_index == CFG_INTERVAL_LIMIT) begin
                interval_limit_reg <= cfg_data[INTERVAL_W-1:0];
            end
        end
    end

    // Record ring storage.
    tpr_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Request sequencer.
    tpr_core #(
        .RING_DEPTH (RING_DEPTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .pulse_limit    (pulse_limit_reg),
        .interval_limit (interval_limit_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench of the tyre pass recorder with its own record predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tpr_pkg::*;

    localparam int unsigned DEPTH = RING_DEPTH_DEF;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Command codes that the block ignores.
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    // Register indexes that hold no register.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Sides that draw idle cycles.
    localparam int SIDE_TX = 0;
    localparam int SIDE_RX = 1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Requests waiting for the driver, and results waiting for the block.
    in_t pending_reqs[$];
    out_t expected_res[$];

    // Predicted state of the recorder.
    rec_t rec_ring[DEPTH];
    logic [PTR_W-1:0] ring_head;
    logic [QLEN_W-1:0] ring_fill;
    logic tyre_on;
    logic [PULSE_W-1:0] press_ticks;
    logic press_seen;
    logic double_seen;
    logic [PULSE_W-1:0] pulse_lim;
    logic [INTERVAL_W-1:0] interval_lim;

    int mismatches = 0;
    int useful_reqs = 0;
    int tx_gap = 0;
    int rx_hold = 0;
    int unsigned cycle_cnt = 0;
    bit calm_mode[2] = '{1'b0, 1'b0};
    out_t got_want;

    tyre_pass_recorder_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run guard.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Idle cycles for one side; now and then a side switches to or from a calm stretch.
    function automatic int draw_wait(int side);
        if ($urandom_range(47, 0) == 0) begin
            calm_mode[side] = !calm_mode[side];
        end
        return calm_mode[side] ? 0 : $urandom_range(3, 0);
    endfunction

    // Applies one request to the predicted recorder and returns the result it gives.
    function automatic out_t recorder_step(in_t req);
        out_t res;
        logic [PTR_W-1:0] idx;
        logic release_now;
        res = '0;
        release_now = 1'b0;
        case (req.command)
            CMD_TICK: begin
                press_seen = req.press_level;
                double_seen = req.double_level;
                // The gap after the newest tyre grows on every tick that starts unpressed, up to the interval limit.
                if (!tyre_on && ring_fill != 0) begin
                    idx = ring_head + PTR_W'(ring_fill - 1);
                    if (rec_ring[idx].interval < interval_lim) begin
                        rec_ring[idx].interval = rec_ring[idx].interval + INTERVAL_W'(1);
                    end
                end
                if (req.press_level) begin
                    if (!tyre_on) begin
                        tyre_on = 1'b1;
                        press_ticks = '0;
                    end
                end else if (tyre_on) begin
                    tyre_on = 1'b0;
                    release_now = 1'b1;
                end
                if (tyre_on && press_ticks < pulse_lim) begin
                    press_ticks = press_ticks + PULSE_W'(1);
                end
                // A release stores a record; a full ring drops its oldest one.
                if (release_now) begin
                    idx = ring_head + PTR_W'(ring_fill);
                    rec_ring[idx].pulse = press_ticks;
                    rec_ring[idx].interval = '0;
                    rec_ring[idx].dbl = req.double_level;
                    if (ring_fill == QLEN_W'(DEPTH)) begin
                        ring_head = ring_head + PTR_W'(1);
                    end else begin
                        ring_fill = ring_fill + QLEN_W'(1);
                    end
                end
            end
            CMD_POP, CMD_PEEK_OLD, CMD_PEEK_NEW: begin
                if (ring_fill == 0) begin
                    res.empty_res = 1'b1;
                end else begin
                    idx = (req.command == CMD_PEEK_NEW) ? ring_head + PTR_W'(ring_fill - 1)
                                                        : ring_head;
                    res.pulse_count = rec_ring[idx].pulse;
                    res.interval_count = rec_ring[idx].interval;
                    res.double_tyre = rec_ring[idx].dbl;
                    if (req.command == CMD_POP) begin
                        ring_head = ring_head + PTR_W'(1);
                        ring_fill = ring_fill - QLEN_W'(1);
                    end
                end
            end
            CMD_CLEAR: begin
                ring_head = '0;
                ring_fill = '0;
            end
            default: begin
            end
        endcase
        res.queue_length = ring_fill;
        res.press_now = press_seen;
        res.double_now = double_seen;
        return res;
    endfunction

    // Driver: presents queued requests and predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
            ring_head = '0;
            ring_fill = '0;
            tyre_on = 1'b0;
            press_ticks = '0;
            press_seen = 1'b0;
            double_seen = 1'b0;
            pulse_lim = PULSE_LIMIT_RST;
            interval_lim = INTERVAL_LIMIT_RST;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_PULSE_LIMIT) begin
                    pulse_lim = cfg_data[PULSE_W-1:0];
                end else if (cfg_index == CFG_INTERVAL_LIMIT) begin
                    interval_lim = cfg_data[INTERVAL_W-1:0];
                end
            end
            if (s_valid && s_ready) begin
                expected_res.push_back(recorder_step(s_data));
                tx_gap = draw_wait(SIDE_TX);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap == 0 && pending_reqs.size() != 0) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                    if (tx_gap > 0) begin
                        tx_gap--;
                    end
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: takes results with random stalls and compares them with the predictions.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_res.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none actual %h", $time, m_data);
                end else begin
                    got_want = expected_res.pop_front();
                    check_field("empty_res", 32'(got_want.empty_res),
                                32'(m_data.empty_res));
                    check_field("pulse_count", 32'(got_want.pulse_count),
                                32'(m_data.pulse_count));
                    check_field("interval_count", 32'(got_want.interval_count),
                                32'(m_data.interval_count));
                    check_field("double_tyre", 32'(got_want.double_tyre),
                                32'(m_data.double_tyre));
                    check_field("queue_length", 32'(got_want.queue_length),
                                32'(m_data.queue_length));
                    check_field("press_now", 32'(got_want.press_now),
                                32'(m_data.press_now));
                    check_field("double_now", 32'(got_want.double_now),
                                32'(m_data.double_now));
                end
                rx_hold = draw_wait(SIDE_RX);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_ready <= (rx_hold == 0);
        end
    end

    task automatic add_req(logic [CMD_W-1:0] cmd, logic press, logic dbl);
        in_t req;
        req.command = cmd;
        req.press_level = press;
        req.double_level = dbl;
        pending_reqs.push_back(req);
        if (cmd <= CMD_CLEAR) begin
            useful_reqs++;
        end
    endtask

    // Waits until every request is taken and every result is back, then lets the block settle.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_reqs.size() != 0 || s_valid || expected_res.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly whole tyre passes (press, release, gap) with reads in between, plus noise.
    task automatic gen_passes(int n, int pop_pct);
        int start;
        int len;
        logic [CMD_W-1:0] cmd;
        start = useful_reqs;
        while (useful_reqs - start < n) begin
            if ($urandom_range(99, 0) < 70) begin
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 10)
                                                  : $urandom_range(8, 1);
                repeat (len) add_req(CMD_TICK, 1'b1, 1'($urandom_range(1, 0)));
                add_req(CMD_TICK, 1'b0, 1'($urandom_range(1, 0)));
                repeat ($urandom_range(6, 0)) add_req(CMD_TICK, 1'b0, 1'($urandom_range(1, 0)));
                if ($urandom_range(99, 0) < pop_pct) begin
                    add_req(CMD_POP, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                end
                if ($urandom_range(3, 0) == 0) begin
                    cmd = $urandom_range(1, 0) ? CMD_PEEK_NEW : CMD_PEEK_OLD;
                    add_req(cmd, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                end
            end else begin
                cmd = CMD_W'($urandom_range(CMD_RSVD_HI, CMD_TICK));
                // Clears are kept rare so that the ring gets a chance to fill.
                if (cmd == CMD_CLEAR && $urandom_range(3, 0) != 0) begin
                    cmd = CMD_TICK;
                end
                add_req(cmd, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            end
        end
    endtask

    // One phase: new limits while idle, then random traffic.
    task automatic run_phase(logic [CFG_DATA_W-1:0] plim, logic [CFG_DATA_W-1:0] ilim,
                             int n, int pop_pct, bit poke_spare);
        wait_drained();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PULSE_LIMIT;
        cfg_data <= plim;
        @(posedge aclk);
        cfg_index <= CFG_INTERVAL_LIMIT;
        cfg_data <= ilim;
        if (poke_spare) begin
            @(posedge aclk);
            cfg_index <= CFG_SPARE_LO;
            cfg_data <= '0;
            @(posedge aclk);
            cfg_index <= CFG_SPARE_HI;
            cfg_data <= '1;
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        gen_passes(n, pop_pct);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests at the reset limits.
        add_req(CMD_PEEK_NEW, 1'b0, 1'b0);
        add_req(CMD_POP, 1'b1, 1'b1);
        add_req(CMD_PEEK_OLD, 1'b0, 1'b0);
        add_req(CMD_RSVD_LO, 1'b1, 1'b1);
        add_req(CMD_RSVD_LO + CMD_W'(1), 1'b0, 1'b1);
        add_req(CMD_RSVD_HI, 1'b1, 1'b0);
        add_req(CMD_TICK, 1'b1, 1'b1);
        add_req(CMD_TICK, 1'b1, 1'b0);
        add_req(CMD_TICK, 1'b0, 1'b1);
        add_req(CMD_TICK, 1'b0, 1'b0);
        add_req(CMD_PEEK_OLD, 1'b0, 1'b0);
        add_req(CMD_PEEK_NEW, 1'b0, 1'b0);
        add_req(CMD_TICK, 1'b1, 1'b0);
        add_req(CMD_TICK, 1'b0, 1'b0);
        add_req(CMD_POP, 1'b0, 1'b0);
        add_req(CMD_PEEK_NEW, 1'b0, 1'b0);
        add_req(CMD_CLEAR, 1'b0, 1'b0);
        add_req(CMD_PEEK_NEW, 1'b0, 1'b0);
        // A clear in the middle of a press keeps the press going.
        add_req(CMD_TICK, 1'b1, 1'b1);
        add_req(CMD_CLEAR, 1'b0, 1'b0);
        add_req(CMD_TICK, 1'b0, 1'b1);
        add_req(CMD_POP, 1'b0, 1'b0);
        add_req(CMD_POP, 1'b0, 1'b0);
        gen_passes(260, 40);

        run_phase('0, '0, 150, 40, 1'b0);
        run_phase(CFG_DATA_W'(1), CFG_DATA_W'(1), 250, 20, 1'b0);
        run_phase(CFG_DATA_W'(3), CFG_DATA_W'(5), 300, 50, 1'b0);
        run_phase('1, '1, 250, 60, 1'b1);
        run_phase(CFG_DATA_W'($urandom_range(40, 1)), CFG_DATA_W'($urandom_range(60, 1)),
                  300, 30, 1'b0);
        run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 100, 50, 1'b0);

        wait_drained();
        mismatches += expected_res.size();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
